[sv/msort_pkg.sv]
// shared types for the merge sort engine
package msort_pkg;

   // one input transaction
   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               final_res;
      logic               dropped;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic sort_init;
      logic merge_wr;
      logic out_wr;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sort_needed;
      logic sort_done;
      logic out_done;
   } ctrl_sts_type;

endpackage

[sv/msort_ctrl.sv]
// controller state machine for the merge sort engine
module msort_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    last,
   output logic                    busy,
   output msort_pkg::ctrl_cmd_type cmd,
   input  msort_pkg::ctrl_sts_type sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MRD  = 3'd1;
   localparam logic [2:0] ST_MWR  = 3'd2;
   localparam logic [2:0] ST_ORD  = 3'd3;
   localparam logic [2:0] ST_OWR  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last) begin
                  if (sts.sort_needed) begin
                     cmd.sort_init = 1'b1;
                     state_in      = ST_MRD;
                  end else begin
                     state_in = ST_ORD;
                  end
               end
            end
         end
         ST_MRD: begin
            state_in = ST_MWR;
         end
         ST_MWR: begin
            cmd.merge_wr = 1'b1;
            state_in     = sts.sort_done ? ST_ORD : ST_MRD;
         end
         ST_ORD: begin
            state_in = ST_OWR;
         end
         ST_OWR: begin
            cmd.out_wr = 1'b1;
            state_in   = sts.out_done ? ST_IDLE : ST_ORD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/msort_dp.sv]
// datapath for the merge sort engine: two stores, merge pointers, comparator
module msort_dp #(
   parameter int MAX_ITEMS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  msort_pkg::req_type      req_data,
   input  msort_pkg::ctrl_cmd_type cmd,
   output msort_pkg::ctrl_sts_type sts,
   output logic                    rsp_strobe,
   output msort_pkg::rsp_type      rsp_data
);

   localparam int IW    = $clog2(MAX_ITEMS);
   localparam int CW    = $clog2(MAX_ITEMS + 1);
   localparam int PW    = CW + 1;
   localparam int DEPTH = 1 << IW;

   function automatic logic [PW-1:0] min_p(input logic [PW-1:0] x, input logic [PW-1:0] y);
      min_p = (x < y) ? x : y;
   endfunction

   logic [31:0]   mem0 [DEPTH];
   logic [31:0]   mem1 [DEPTH];
   logic [31:0]   m0a_ff, m0b_ff, m1a_ff, m1b_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          src_ff, src_in;
   logic [PW-1:0] a_ff, a_in, b_ff, b_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [PW-1:0] k_ff, k_in, w_ff, w_in;

   logic                rsp_strobe_ff;
   msort_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic          room;
   logic [CW-1:0] n_next;
   logic [PW-1:0] n, a1, k1, w2, w4, seg_mid;
   logic [31:0]   ra, rb, merged;
   logic          a_ok, b_ok, take_a, pass_end;

   logic          wr_en0, wr_en1;
   logic [IW-1:0] wr_addr0, wr_addr1;
   logic [31:0]   wr_data0;

   always_comb begin
      room     = count_ff < CW'(MAX_ITEMS);
      n_next   = room ? count_ff + CW'(1) : count_ff;
      n        = {1'b0, count_ff};
      ra       = src_ff ? m1a_ff : m0a_ff;
      rb       = src_ff ? m1b_ff : m0b_ff;
      a_ok     = a_ff < mid_ff;
      b_ok     = b_ff < hi_ff;
      take_a   = a_ok && (!b_ok || ($signed(ra) < $signed(rb)));
      merged   = take_a ? ra : rb;
      a1       = a_ff + PW'(1);
      k1       = k_ff + PW'(1);
      w2       = {w_ff[PW-2:0], 1'b0};
      w4       = {w_ff[PW-3:0], 2'b00};
      seg_mid  = min_p(hi_ff + w_ff, n);
      pass_end = (k1 == n);

      sts.sort_needed = n_next > CW'(1);
      sts.sort_done   = pass_end && (w2 >= n);
      sts.out_done    = (a1 == n);
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      src_in      = src_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      mid_in      = mid_ff;
      hi_in       = hi_ff;
      k_in        = k_ff;
      w_in        = w_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
         a_in = '0;
         k_in = '0;
      end
      if (cmd.sort_init) begin
         w_in   = PW'(1);
         a_in   = '0;
         b_in   = PW'(1);
         mid_in = PW'(1);
         hi_in  = PW'(2);
         k_in   = '0;
      end
      if (cmd.merge_wr) begin
         k_in = k1;
         if (take_a) begin
            a_in = a1;
         end else begin
            b_in = b_ff + PW'(1);
         end
         if (pass_end) begin
            // pass complete: the destination store now holds the runs
            src_in = !src_ff;
            k_in   = '0;
            a_in   = '0;
            if (!sts.sort_done) begin
               w_in   = w2;
               mid_in = min_p(w2, n);
               b_in   = min_p(w2, n);
               hi_in  = min_p(w4, n);
            end
         end else if (k1 == hi_ff) begin
            // next pair of runs
            a_in   = hi_ff;
            mid_in = seg_mid;
            b_in   = seg_mid;
            hi_in  = min_p(hi_ff + w2, n);
         end
      end
      if (cmd.out_wr) begin
         a_in = a1;
         if (sts.out_done) begin
            count_in    = '0;
            overflow_in = 1'b0;
            src_in      = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_data_in.sorted_value = $signed(ra);
      rsp_data_in.final_res    = sts.out_done;
      rsp_data_in.dropped      = overflow_ff;
      wr_en0   = (cmd.load && room) || (cmd.merge_wr && src_ff);
      wr_addr0 = cmd.load ? count_ff[IW-1:0] : k_ff[IW-1:0];
      wr_data0 = cmd.load ? req_data.value : merged;
      wr_en1   = cmd.merge_wr && !src_ff;
      wr_addr1 = k_ff[IW-1:0];
   end

   // store 0 takes the loaded run
   always_ff @(posedge clock) begin
      if (wr_en0) begin
         mem0[wr_addr0] <= wr_data0;
      end
      m0a_ff <= mem0[a_ff[IW-1:0]];
      m0b_ff <= mem0[b_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_en1) begin
         mem1[wr_addr1] <= merged;
      end
      m1a_ff <= mem1[a_ff[IW-1:0]];
      m1b_ff <= mem1[b_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         src_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         src_ff        <= src_in;
         rsp_strobe_ff <= cmd.out_wr;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      k_ff   <= k_in;
      w_ff   <= w_in;
      if (cmd.out_wr) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[sv/merge_sort_engine_unit.sv]
// top level of the merge sort engine
// usage:
// - a run of signed values comes in one transaction per cycle on req_data, taken
//   when start is high and busy is low; req_data.last marks the final value
// - up to MAX_ITEMS values are kept; later values of the run are dropped and every
//   result of that run then has dropped set
// - busy stays low while loading
// - on the last transaction busy rises and, if more than one value is kept, a bottom-up
//   merge sort runs between two stores, alternating direction each pass; each merged
//   element needs a registered store read, then a compare and write, and there are
//   ceil(log2 n) passes
// - results then leave in ascending order, each read from the store and then shown
//   on rsp_data with rsp_strobe high for one cycle; the last has final_res set
// - the receiver cannot stall; results must be taken when the strobe is high
// - reset clears the controller, the element count and the dropped flag; the
//   stores are not cleared since only entries of the current run are read
module merge_sort_engine_unit #(
   parameter int MAX_ITEMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  msort_pkg::req_type req_data,
   output logic               rsp_strobe,
   output msort_pkg::rsp_type rsp_data
);

   // command and status between controller and datapath
   msort_pkg::ctrl_cmd_type cmd;
   msort_pkg::ctrl_sts_type sts;

   // sequencing of load, merge passes and output
   msort_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .last  (req_data.last),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // stores, merge pointers and comparator
   msort_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
